// ----- rtl/core/scfe_pkg.sv -----
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared constants and types of the stereo cross-feedback echo core: delay
// line geometry, configuration layout, pipeline control and result frames.
// ----------------------------------------------------------------------------
package scfe_pkg;

    localparam int MAX_DELAY = 4096;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int CNT_W     = $clog2(MAX_DELAY + 1);
    localparam int DLEN_W    = 13;
    localparam int DL_W      = (CNT_W > DLEN_W) ? CNT_W : DLEN_W;
    localparam int GAIN_W    = 17;
    localparam int MODE_W    = 2;
    localparam int WORD_W    = 32;
    localparam int SMP_W     = 16;
    localparam int PROD_W    = 35;
    localparam int QDEPTH    = 4;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int LVL_W     = $clog2(QDEPTH + 1);
    localparam int INF_W     = LVL_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam int MODE_STEREO_BIT = 0;
    localparam int MODE_WIDE_BIT   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRY_GAIN         = 3'd0,
        CFG_WET_GAIN         = 3'd1,
        CFG_FB_DELAYED_SAME  = 3'd2,
        CFG_FB_DELAYED_OTHER = 3'd3,
        CFG_FB_NEW_SAME      = 3'd4,
        CFG_FB_NEW_OTHER     = 3'd5,
        CFG_DELAY_LENGTH     = 3'd6,
        CFG_FORMAT_MODE      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] dry_gain;
        logic [GAIN_W-1:0] wet_gain;
        logic [GAIN_W-1:0] fb_delayed_same;
        logic [GAIN_W-1:0] fb_delayed_other;
        logic [GAIN_W-1:0] fb_new_same;
        logic [GAIN_W-1:0] fb_new_other;
        logic [DLEN_W-1:0] delay_length;
        logic [MODE_W-1:0] format_mode;
    } t_cfg;

    typedef enum logic [1:0] {
        DSEL_ZERO = 2'd0,
        DSEL_MEM  = 2'd1,
        DSEL_FWD  = 2'd2
    } t_dsel;

    typedef struct packed {
        logic              s1_valid;
        t_dsel             s1_sel;
        logic              s2_valid;
        logic [ADDR_W-1:0] s2_wp;
    } t_pipe_ctl;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } t_frame;

endpackage

// ----- rtl/core/stereo_cross_feedback_echo_core.sv -----
// ----------------------------------------------------------------------------
// stereo_cross_feedback_echo_core
// Stereo echo with cross feedback through a 4096-frame delay line.
//
// Input channel: i_in_valid with o_in_stall carries one frame (i_left_in,
// i_right_in). Output channel: o_out_valid with i_out_stall carries the mixed
// frame (o_left_out, o_right_out). Configuration: i_cfg_valid/o_cfg_ready
// writes register i_cfg_index with i_cfg_data; write only while idle.
// Path: an accepted frame passes the delay-line read, the product stage and
// the sum and saturate stage into the result queue that feeds the output.
// Throughput: one frame per cycle while the output does not stall, for an
// effective delay of two frames or more. At a delay of one frame a new frame
// is held while the previous one is still in the read stage, as the feedback
// path runs from that read via the product and sum stages to the write port.
// Reset: clears write position, fill count, pipeline and result queue. The
// delay line is not swept; entries not yet written since reset read as zero
// via the fill count, so the block takes items from the first cycle.
// Stall: a four-entry result queue holds finished frames; o_in_stall rises
// when queued plus in-flight frames reach four, or on the delay hazard above.
// ----------------------------------------------------------------------------
module stereo_cross_feedback_echo_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scfe_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [31:0]             i_left_in,
    input  logic signed [31:0]             i_right_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [31:0]             o_left_out,
    output logic signed [31:0]             o_right_out
);
    import scfe_pkg::*;

    t_cfg              r_cfg;
    t_pipe_ctl         ctl;
    t_frame            res;
    t_frame            q_data;
    logic              accept;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] wdata;
    logic [LVL_W-1:0]  q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry_gain         <= 17'd65536;
            r_cfg.wet_gain         <= '0;
            r_cfg.fb_delayed_same  <= '0;
            r_cfg.fb_delayed_other <= '0;
            r_cfg.fb_new_same      <= 17'd65536;
            r_cfg.fb_new_other     <= '0;
            r_cfg.delay_length     <= 13'd1024;
            r_cfg.format_mode      <= 2'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DRY_GAIN:         r_cfg.dry_gain         <= i_cfg_data;
                CFG_WET_GAIN:         r_cfg.wet_gain         <= i_cfg_data;
                CFG_FB_DELAYED_SAME:  r_cfg.fb_delayed_same  <= i_cfg_data;
                CFG_FB_DELAYED_OTHER: r_cfg.fb_delayed_other <= i_cfg_data;
                CFG_FB_NEW_SAME:      r_cfg.fb_new_same      <= i_cfg_data;
                CFG_FB_NEW_OTHER:     r_cfg.fb_new_other     <= i_cfg_data;
                CFG_DELAY_LENGTH:     r_cfg.delay_length     <= i_cfg_data[DLEN_W-1:0];
                CFG_FORMAT_MODE:      r_cfg.format_mode      <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    scfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dlen     (r_cfg.delay_length),
        .i_in_valid (i_in_valid),
        .i_q_level  (q_level),
        .o_in_stall (o_in_stall),
        .o_accept   (accept),
        .o_raddr    (raddr),
        .o_ctl      (ctl)
    );

    scfe_ram #(
        .DEPTH (MAX_DELAY),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.s2_valid),
        .i_waddr (ctl.s2_wp),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    scfe_mac u_mac (
        .i_clk      (i_clk),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .i_rdata    (rdata),
        .i_ctl      (ctl),
        .o_wdata    (wdata),
        .o_res      (res)
    );

    scfe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (ctl.s2_valid),
        .i_data      (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_data      (q_data),
        .o_level     (q_level)
    );

    assign o_left_out  = q_data.left;
    assign o_right_out = q_data.right;

endmodule

// ----- rtl/core/scfe_ram.sv -----
// ----------------------------------------------------------------------------
// scfe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scfe_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/scfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// scfe_ctrl
// Delay line addressing: write position, fill count, read address, hazard
// interlock, output credit check and forwarding select.
// ----------------------------------------------------------------------------
module scfe_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [scfe_pkg::DLEN_W-1:0]   i_dlen,
    input  logic                          i_in_valid,
    input  logic [scfe_pkg::LVL_W-1:0]    i_q_level,
    output logic                          o_in_stall,
    output logic                          o_accept,
    output logic [scfe_pkg::ADDR_W-1:0]   o_raddr,
    output scfe_pkg::t_pipe_ctl           o_ctl
);
    import scfe_pkg::*;

    logic [DL_W-1:0]   dl_ext;
    logic [DL_W-1:0]   dl_eff;
    logic [DL_W-1:0]   wp_ext;
    logic [DL_W-1:0]   rp_wide;
    logic [ADDR_W-1:0] rp;
    logic [INF_W-1:0]  inflight;
    logic              hazard;
    logic              full;
    logic              written;
    t_dsel             sel;

    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_wp;
    logic [ADDR_W-1:0] r_s1_rp;
    logic              r_s1_written;
    logic              r_s2_valid;
    logic [ADDR_W-1:0] r_s2_wp;
    logic              r_last_valid;
    logic [ADDR_W-1:0] r_last_addr;

    always_comb begin
        dl_ext = DL_W'(i_dlen);
        if (dl_ext == '0) begin
            dl_eff = DL_W'(1);
        end else if (dl_ext > DL_W'(MAX_DELAY)) begin
            dl_eff = DL_W'(MAX_DELAY);
        end else begin
            dl_eff = dl_ext;
        end
        wp_ext = DL_W'(r_wp);
        if (wp_ext >= dl_eff) begin
            rp_wide = wp_ext - dl_eff;
        end else begin
            rp_wide = wp_ext + DL_W'(MAX_DELAY) - dl_eff;
        end
        rp = rp_wide[ADDR_W-1:0];
    end

    always_comb begin
        hazard     = r_s1_valid && (r_s1_wp == rp);
        inflight   = INF_W'(i_q_level) + INF_W'(r_s1_valid) + INF_W'(r_s2_valid);
        full       = inflight >= INF_W'(QDEPTH);
        o_in_stall = hazard || full;
        o_accept   = i_in_valid && !o_in_stall;
        written    = DL_W'(r_fill) >= dl_eff;
        n_wp       = (r_wp == ADDR_W'(MAX_DELAY - 1)) ? '0 : r_wp + ADDR_W'(1);
        n_fill     = (r_fill == CNT_W'(MAX_DELAY)) ? r_fill : r_fill + CNT_W'(1);
    end

    always_comb begin
        if (!r_s1_written) begin
            sel = DSEL_ZERO;
        end else if (r_last_valid && (r_last_addr == r_s1_rp)) begin
            sel = DSEL_FWD;
        end else begin
            sel = DSEL_MEM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_fill       <= '0;
            r_s1_valid   <= 1'b0;
            r_s1_wp      <= '0;
            r_s1_rp      <= '0;
            r_s1_written <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s2_wp      <= '0;
            r_last_valid <= 1'b0;
            r_last_addr  <= '0;
        end else begin
            r_s1_valid <= o_accept;
            if (o_accept) begin
                r_s1_wp      <= r_wp;
                r_s1_rp      <= rp;
                r_s1_written <= written;
                r_wp         <= n_wp;
                r_fill       <= n_fill;
            end
            r_s2_valid <= r_s1_valid;
            r_s2_wp    <= r_s1_wp;
            if (r_s2_valid) begin
                r_last_valid <= 1'b1;
                r_last_addr  <= r_s2_wp;
            end
        end
    end

    assign o_raddr        = rp;
    assign o_ctl.s1_valid = r_s1_valid;
    assign o_ctl.s1_sel   = sel;
    assign o_ctl.s2_valid = r_s2_valid;
    assign o_ctl.s2_wp    = r_s2_wp;

endmodule

// ----- rtl/core/scfe_mac.sv -----
// ----------------------------------------------------------------------------
// scfe_mac
// Mix and feedback datapath: sample capture, product stage, sum and
// saturate stage, forwarded delay-line word.
// ----------------------------------------------------------------------------
module scfe_mac (
    input  logic                        i_clk,
    input  scfe_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic [scfe_pkg::WORD_W-1:0] i_left_in,
    input  logic [scfe_pkg::WORD_W-1:0] i_right_in,
    input  logic [scfe_pkg::WORD_W-1:0] i_rdata,
    input  scfe_pkg::t_pipe_ctl         i_ctl,
    output logic [scfe_pkg::WORD_W-1:0] o_wdata,
    output scfe_pkg::t_frame            o_res
);
    import scfe_pkg::*;

    function automatic logic signed [PROD_W-1:0] gmul(input logic [GAIN_W-1:0] g,
                                                      input logic signed [16:0] s);
        logic signed [PROD_W-1:0] ge;
        logic signed [PROD_W-1:0] se;
        ge = $signed({{(PROD_W-GAIN_W){1'b0}}, g});
        se = {{(PROD_W-17){s[16]}}, s};
        return ge * se;
    endfunction

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [20:0] x);
        logic signed [SMP_W-1:0] y;
        if (x > 21'sh007FFF) begin
            y = 16'sh7FFF;
        end else if (x < 21'sh1F8000) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [35:0] x);
        logic signed [WORD_W-1:0] y;
        if (x > 36'sh07FFFFFFF) begin
            y = 32'sh7FFFFFFF;
        end else if (x < 36'shF80000000) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [36:0] ext37(input logic signed [PROD_W-1:0] x);
        return {{(37-PROD_W){x[PROD_W-1]}}, x};
    endfunction

    logic                     stereo;
    logic                     wide;
    logic [WORD_W-1:0]        d_word;
    logic signed [16:0]       sl;
    logic signed [16:0]       sr;
    logic signed [16:0]       dlf;
    logic signed [16:0]       drt;
    logic signed [16:0]       dlf1;
    logic signed [16:0]       drt1;
    logic signed [35:0]       mix_l;
    logic signed [35:0]       mix_r;
    logic signed [36:0]       fb_l;
    logic signed [36:0]       fb_r;
    logic signed [SMP_W-1:0]  nar_l;
    logic signed [SMP_W-1:0]  nar_r;
    logic signed [WORD_W-1:0] out_l;
    logic signed [WORD_W-1:0] out_r;
    logic [SMP_W-1:0]         fbw_l;
    logic [SMP_W-1:0]         fbw_r;

    logic signed [SMP_W-1:0]  r_s1_sl;
    logic signed [SMP_W-1:0]  r_s1_sr;
    logic signed [PROD_W-1:0] r_p_dry_l, r_p_wet_l, r_p_dry_r, r_p_wet_r;
    logic signed [PROD_W-1:0] r_p_l0, r_p_l1, r_p_l2, r_p_l3;
    logic signed [PROD_W-1:0] r_p_r0, r_p_r1, r_p_r2, r_p_r3;
    logic [WORD_W-1:0]        r_last_data;

    assign stereo = i_cfg.format_mode[MODE_STEREO_BIT];
    assign wide   = i_cfg.format_mode[MODE_WIDE_BIT];

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_sl <= wide ? i_left_in[31:16]  : i_left_in[15:0];
            r_s1_sr <= wide ? i_right_in[31:16] : i_right_in[15:0];
        end
    end

    always_comb begin
        case (i_ctl.s1_sel)
            DSEL_MEM: d_word = i_rdata;
            DSEL_FWD: d_word = r_last_data;
            default:  d_word = '0;
        endcase
        dlf  = {d_word[15], d_word[15:0]};
        drt  = {d_word[31], d_word[31:16]};
        dlf1 = dlf + 17'sd1;
        drt1 = drt + 17'sd1;
        sl   = {r_s1_sl[SMP_W-1], r_s1_sl};
        sr   = {r_s1_sr[SMP_W-1], r_s1_sr};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_valid) begin
            r_p_dry_l <= gmul(i_cfg.dry_gain, sl);
            r_p_wet_l <= gmul(i_cfg.wet_gain, dlf);
            r_p_dry_r <= gmul(i_cfg.dry_gain, sr);
            r_p_wet_r <= gmul(i_cfg.wet_gain, drt);
            r_p_l0    <= gmul(i_cfg.fb_delayed_same, dlf1);
            r_p_l1    <= gmul(i_cfg.fb_delayed_other, drt1);
            r_p_l2    <= gmul(i_cfg.fb_new_same, sl);
            r_p_l3    <= gmul(i_cfg.fb_new_other, sr);
            r_p_r0    <= gmul(i_cfg.fb_delayed_same, drt1);
            r_p_r1    <= gmul(i_cfg.fb_delayed_other, dlf1);
            r_p_r2    <= gmul(i_cfg.fb_new_same, sr);
            r_p_r3    <= gmul(i_cfg.fb_new_other, sl);
        end
    end

    always_comb begin
        mix_l = {r_p_dry_l[PROD_W-1], r_p_dry_l} + {r_p_wet_l[PROD_W-1], r_p_wet_l};
        mix_r = {r_p_dry_r[PROD_W-1], r_p_dry_r} + {r_p_wet_r[PROD_W-1], r_p_wet_r};
        fb_l  = ext37(r_p_l0) + ext37(r_p_l2);
        if (stereo) begin
            fb_l = fb_l + ext37(r_p_l1) + ext37(r_p_l3);
        end
        fb_r  = ext37(r_p_r0) + ext37(r_p_r1) + ext37(r_p_r2) + ext37(r_p_r3);
        nar_l = sat16({mix_l[35], mix_l[35:16]});
        nar_r = sat16({mix_r[35], mix_r[35:16]});
        out_l = wide ? sat32(mix_l) : {{(WORD_W-SMP_W){nar_l[SMP_W-1]}}, nar_l};
        out_r = wide ? sat32(mix_r) : {{(WORD_W-SMP_W){nar_r[SMP_W-1]}}, nar_r};
        fbw_l = sat16(fb_l[36:16]);
        fbw_r = stereo ? sat16(fb_r[36:16]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_valid) begin
            r_last_data <= {fbw_r, fbw_l};
        end
    end

    assign o_wdata     = {fbw_r, fbw_l};
    assign o_res.left  = out_l;
    assign o_res.right = stereo ? out_r : '0;

endmodule

// ----- rtl/core/scfe_outq.sv -----
// ----------------------------------------------------------------------------
// scfe_outq
// Result queue between the datapath and the output channel; holds the head
// item while the receiver stalls.
// ----------------------------------------------------------------------------
module scfe_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  scfe_pkg::t_frame           i_data,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output scfe_pkg::t_frame           o_data,
    output logic [scfe_pkg::LVL_W-1:0] o_level
);
    import scfe_pkg::*;

    t_frame            r_q [QDEPTH];
    logic [QA_W-1:0]   r_head, n_head;
    logic [QA_W-1:0]   r_tail, n_tail;
    logic [LVL_W-1:0]  r_level, n_level;
    logic              pop;

    always_comb begin
        pop     = (r_level != '0) && !i_out_stall;
        n_head  = (r_head == QA_W'(QDEPTH - 1)) ? '0 : r_head + QA_W'(1);
        n_tail  = (r_tail == QA_W'(QDEPTH - 1)) ? '0 : r_tail + QA_W'(1);
        n_level = r_level + LVL_W'(i_push) - LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (pop) begin
                r_head <= n_head;
            end
            if (i_push) begin
                r_tail <= n_tail;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= i_data;
        end
    end

    assign o_out_valid = r_level != '0;
    assign o_data      = r_q[r_head];
    assign o_level     = r_level;

endmodule

// ----- rtl/core/scfe_checker.sv -----
// ----------------------------------------------------------------------------
// scfe_checker
// Port-level checks of the echo core: reset state, pipeline latency, result
// origin and output hold under stall.
// ----------------------------------------------------------------------------
module scfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_left_out,
    input logic [31:0] o_right_out
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("core not idle after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##2 o_out_valid)
        else $error("accepted item not on output after three cycles");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3))
        else $error("result without matching accepted item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled output item changed");

endmodule

bind stereo_cross_feedback_echo_core scfe_checker u_scfe_checker (.*);

// ----- sim/tb_stereo_cross_feedback_echo_core.sv -----
// ----------------------------------------------------------------------------
// tb_stereo_cross_feedback_echo_core
// Self-checking bench for the stereo cross-feedback echo core. Frames are fed
// through a stalling input channel while the output side stalls at random. A
// local model of the delay line, gains and saturation predicts each mixed
// frame, and each result is compared field by field in order. The register
// set changes between phases, covering mono and stereo, both buffer formats
// and delays from zero to beyond the line depth.
// ----------------------------------------------------------------------------
module tb_stereo_cross_feedback_echo_core;

    import scfe_pkg::*;

    localparam int     N_REGS      = 8;
    localparam int     QUIET_LIMIT = 2000;
    localparam longint W_MIN       = -(longint'(1) <<< 31);
    localparam longint W_MAX       = (longint'(1) <<< 31) - 1;

    typedef logic [N_REGS-1:0][GAIN_W-1:0] t_reg_set;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    t_cfg_idx            cfg_index = CFG_DRY_GAIN;
    logic [GAIN_W-1:0]   cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic signed [31:0]  left_in   = '0;
    logic signed [31:0]  right_in  = '0;
    logic                out_stall = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_stall;
    logic                o_out_valid;
    logic signed [31:0]  o_left_out;
    logic signed [31:0]  o_right_out;

    t_cfg                regs;
    logic [31:0]         echo_line [MAX_DELAY];
    logic [ADDR_W-1:0]   echo_wp = '0;

    t_frame              frames_to_send [$];
    t_frame              mix_due [$];
    t_frame              cur_frame;
    t_frame              want_mix;
    int                  frames_queued = 0;
    int                  frames_sent   = 0;
    int                  mixes_seen    = 0;
    int                  settings_cnt  = 1;
    int                  faults        = 0;
    int                  in_gap        = 0;
    int                  out_gap       = 0;
    int                  quiet         = 0;
    bit                  idle_en       = 1'b1;

    logic [31:0] extreme_words [8] = '{
        32'h7FFFFFFF, 32'h80000000, 32'h00007FFF, 32'hFFFF8000,
        32'h00008000, 32'h0000FFFF, 32'h00000000, 32'hFFFFFFFF
    };

    stereo_cross_feedback_echo_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_left_in   (left_in),
        .i_right_in  (right_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    always #4 clk = ~clk;

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint take(logic [31:0] w, logic wide);
        return wide ? (longint'($signed(w)) >>> 16) : longint'($signed(w[15:0]));
    endfunction

    function automatic logic [31:0] mix(longint s, longint d, logic wide);
        longint acc;
        acc = longint'(regs.dry_gain) * s + longint'(regs.wet_gain) * d;
        if (wide)
            return 32'(clip(acc, W_MIN, W_MAX));
        return 32'(clip(acc >>> 16, -32768, 32767));
    endfunction

    function automatic logic [15:0] feed(longint ds, longint dx, longint ns, longint nx,
                                         logic both);
        longint acc;
        acc = longint'(regs.fb_delayed_same) * (ds + 1) + longint'(regs.fb_new_same) * ns;
        if (both)
            acc += longint'(regs.fb_delayed_other) * (dx + 1)
                 + longint'(regs.fb_new_other) * nx;
        return 16'(clip(acc >>> 16, -32768, 32767));
    endfunction

    function automatic t_frame echo_step(t_frame f);
        logic              stereo;
        logic              wide;
        int                eff;
        logic [ADDR_W-1:0] rp;
        logic [31:0]       word;
        longint            dl, dr, sl, sr;
        t_frame            r;
        stereo = regs.format_mode[MODE_STEREO_BIT];
        wide   = regs.format_mode[MODE_WIDE_BIT];
        eff    = int'(regs.delay_length);
        if (eff == 0)
            eff = 1;
        if (eff > MAX_DELAY)
            eff = MAX_DELAY;
        rp   = echo_wp - ADDR_W'(eff);
        word = echo_line[rp];
        dl   = longint'($signed(word[15:0]));
        dr   = longint'($signed(word[31:16]));
        sl   = take(f.left, wide);
        r.left = mix(sl, dl, wide);
        if (stereo) begin
            sr      = take(f.right, wide);
            r.right = mix(sr, dr, wide);
            echo_line[echo_wp] = {feed(dr, dl, sr, sl, 1'b1), feed(dl, dr, sl, sr, 1'b1)};
        end else begin
            r.right = '0;
            echo_line[echo_wp] = {16'h0000, feed(dl, dl, sl, sl, 1'b0)};
        end
        echo_wp = echo_wp + 1'b1;
        return r;
    endfunction

    function automatic void store_reg(t_cfg_idx idx, logic [GAIN_W-1:0] v);
        case (idx)
            CFG_DRY_GAIN:         regs.dry_gain         = v;
            CFG_WET_GAIN:         regs.wet_gain         = v;
            CFG_FB_DELAYED_SAME:  regs.fb_delayed_same  = v;
            CFG_FB_DELAYED_OTHER: regs.fb_delayed_other = v;
            CFG_FB_NEW_SAME:      regs.fb_new_same      = v;
            CFG_FB_NEW_OTHER:     regs.fb_new_other     = v;
            CFG_DELAY_LENGTH:     regs.delay_length     = v[DLEN_W-1:0];
            CFG_FORMAT_MODE:      regs.format_mode      = v[MODE_W-1:0];
            default:              ;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;
            3:       return 17'($urandom_range(0, 65536));
            4:       return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [DLEN_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 13'd1;
            2:       return 13'd2;
            3:       return 13'd3;
            4:       return 13'($urandom_range(4, 16));
            7:       return 13'(MAX_DELAY - 1);
            8:       return 13'(MAX_DELAY);
            9:       return 13'($urandom_range(MAX_DELAY + 1, 8191));
            default: return 13'($urandom_range(17, 300));
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return {h, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000};
            3:       return {{16{h[15]}}, h};
            default: return $urandom();
        endcase
    endfunction

    function automatic t_reg_set random_set();
        t_reg_set v;
        v[CFG_DRY_GAIN]         = pick_gain();
        v[CFG_WET_GAIN]         = pick_gain();
        v[CFG_FB_DELAYED_SAME]  = pick_gain();
        v[CFG_FB_DELAYED_OTHER] = pick_gain();
        v[CFG_FB_NEW_SAME]      = pick_gain();
        v[CFG_FB_NEW_OTHER]     = pick_gain();
        v[CFG_DELAY_LENGTH]     = {4'($urandom), pick_delay()};
        v[CFG_FORMAT_MODE]      = 17'($urandom);
        return v;
    endfunction

    task automatic load_regs(input t_reg_set v);
        t_cfg_idx idx;
        for (int k = 0; k < N_REGS; k++) begin
            idx = t_cfg_idx'(k);
            cfg_index <= idx;
            cfg_data  <= v[k];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!o_cfg_ready);
            store_reg(idx, v[k]);
        end
        cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    task automatic queue_frames(input int n, input bit extremes);
        t_frame f;
        for (int k = 0; k < n; k++) begin
            f.left  = extremes ? extreme_words[k % 8] : pick_word();
            f.right = extremes ? extreme_words[(k + 3) % 8] : pick_word();
            frames_to_send.push_back(f);
        end
        frames_queued += n;
    endtask

    task automatic drain();
        do @(posedge clk); while (frames_sent != frames_queued || mix_due.size() != 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                cur_frame.left  = left_in;
                cur_frame.right = right_in;
                mix_due.push_back(echo_step(cur_frame));
                frames_sent++;
            end
            if (!(in_valid && o_in_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (frames_to_send.size() != 0
                             && !(idle_en && $urandom_range(0, 7) == 0)) begin
                    cur_frame = frames_to_send.pop_front();
                    left_in   <= cur_frame.left;
                    right_in  <= cur_frame.right;
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    if (idle_en && frames_to_send.size() != 0)
                        in_gap = $urandom_range(0, 3);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                mixes_seen++;
                if (mix_due.size() == 0) begin
                    faults++;
                    $display("%0t: unexpected mix, expected none, actual L=%h R=%h",
                             $time, o_left_out, o_right_out);
                end else begin
                    want_mix = mix_due.pop_front();
                    if (o_left_out !== want_mix.left) begin
                        faults++;
                        $display("%0t: left_out expected %h actual %h",
                                 $time, want_mix.left, o_left_out);
                    end
                    if (o_right_out !== want_mix.right) begin
                        faults++;
                        $display("%0t: right_out expected %h actual %h",
                                 $time, want_mix.right, o_right_out);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet == QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("stereo_cross_feedback_echo_core test failed");
                $finish;
            end
        end
    end

    initial begin
        t_reg_set v;
        int       n;
        int       random_sent;
        regs.dry_gain         = 17'd65536;
        regs.wet_gain         = '0;
        regs.fb_delayed_same  = '0;
        regs.fb_delayed_other = '0;
        regs.fb_new_same      = 17'd65536;
        regs.fb_new_other     = '0;
        regs.delay_length     = 13'd1024;
        regs.format_mode      = 2'(1 << MODE_STEREO_BIT);
        foreach (echo_line[k])
            echo_line[k] = '0;
        random_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extreme words
        queue_frames(7, 1'b1);
        drain();

        // full-scale gains, zero delay, stereo 32-bit
        v = {N_REGS{17'h1FFFF}};
        v[CFG_DELAY_LENGTH] = {4'hF, 13'd0};
        load_regs(v);
        queue_frames(7, 1'b1);
        drain();

        // mono 16-bit, one-frame delay, cross weights to be ignored
        v = {N_REGS{17'd65536}};
        v[CFG_FB_DELAYED_OTHER] = 17'h1FFFF;
        v[CFG_FB_NEW_OTHER]     = 17'h1FFFF;
        v[CFG_DELAY_LENGTH]     = 17'd1;
        v[CFG_FORMAT_MODE]      = '0;
        load_regs(v);
        queue_frames(5, 1'b1);
        drain();

        // mono 32-bit, two-frame delay
        v = random_set();
        v[CFG_DELAY_LENGTH] = 17'd2;
        v[CFG_FORMAT_MODE]  = 17'(1 << MODE_WIDE_BIT);
        load_regs(v);
        queue_frames(4, 1'b1);
        drain();

        while (random_sent < 400) begin
            load_regs(random_set());
            n       = $urandom_range(10, 60);
            idle_en = ($urandom_range(0, 3) != 0);
            queue_frames(n, 1'b0);
            drain();
            random_sent += n;
        end

        // full-depth delay
        idle_en = 1'b1;
        v = random_set();
        v[CFG_WET_GAIN]     = 17'($urandom_range(16384, 65536));
        v[CFG_DELAY_LENGTH] = 17'(MAX_DELAY);
        v[CFG_FORMAT_MODE]  = 17'((1 << MODE_STEREO_BIT)
                                  | ($urandom_range(0, 1) << MODE_WIDE_BIT));
        load_regs(v);
        queue_frames(100, 1'b0);
        drain();

        // delay beyond the line depth
        v = random_set();
        v[CFG_DELAY_LENGTH] = 17'($urandom_range(MAX_DELAY + 1, 8191));
        load_regs(v);
        queue_frames(120, 1'b0);
        drain();

        // hold both sides busy for the final stretch
        idle_en = 1'b0;
        v = random_set();
        v[CFG_DELAY_LENGTH] = 17'($urandom_range(1, 3));
        load_regs(v);
        queue_frames(100, 1'b0);
        drain();

        repeat (8) @(posedge clk);
        if (mix_due.size() != 0) begin
            faults++;
            $display("%0t: %0d mixes still outstanding", $time, mix_due.size());
        end
        $display("Sent %0d frames over %0d register settings, %0d mixes compared",
                 frames_sent, settings_cnt, mixes_seen);
        $display("Delays ran from zero to beyond the line depth, %0d faults", faults);
        if (faults == 0)
            $display("stereo_cross_feedback_echo_core test passed");
        else
            $display("stereo_cross_feedback_echo_core test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/scfe_pkg.sv
rtl/core/scfe_ram.sv
rtl/core/scfe_ctrl.sv
rtl/core/scfe_mac.sv
rtl/core/scfe_outq.sv
rtl/core/stereo_cross_feedback_echo_core.sv
rtl/core/scfe_checker.sv
sim/tb_stereo_cross_feedback_echo_core.sv
